@@ hdl/rlcg_pkg.sv @@
// Shared types and constants of the rand_r style LCG range generator.
package rlcg_pkg;

    // Command codes carried in the input tuser field
    localparam logic [1:0] CMD_RAW     = 2'd0;
    localparam logic [1:0] CMD_RANGE   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // LCG recurrence
    localparam logic [31:0] RLCG_LCG_MUL = 32'd1103515245;
    localparam logic [31:0] RLCG_LCG_INC = 32'd12345;
    localparam logic [31:0] RLCG_SEED_RESET = 32'd1;

    // Range scaling divisor, 1 .. 2^32-1
    localparam logic [31:0] RLCG_RANGE_DIVISOR = 32'd2147483647;

    // floor(p / d) == floor(p * m / 2^95) for every p < 2^63 when
    // m = ceil(2^95 / d) and d <= 2^32.
    localparam int unsigned RLCG_RECIP_SHIFT = 95;
    localparam logic [95:0] RLCG_RECIP = 96'(((128'd1 << RLCG_RECIP_SHIFT)
        + 128'(RLCG_RANGE_DIVISOR) - 128'd1) / 128'(RLCG_RANGE_DIVISOR));

    // Default depth of the job queue between front and back (power of two)
    localparam int unsigned RLCG_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        JOB_RAW   = 2'd0,
        JOB_SCALE = 2'd1,
        JOB_EMPTY = 2'd2
    } t_job_kind;

    // One finished draw on its way to the back end
    typedef struct packed {
        t_job_kind   kind;
        logic [30:0] value;
        logic [31:0] low;
        logic [31:0] span;
    } t_draw_job;

endpackage

@@ hdl/rand_r_lcg_range_generator.sv @@
// Top level: rand_r style LCG generator with exact range scaling.
// Raw draws and empty ranges pass the front's three LCG steps, the queue and the output
//   register; a scaled draw holds the back end for its partial products, one per cycle.
// The front takes a new command only after a draw's three steps on the single 32x32 LCG
//   multiplier (one state step per cycle) and the push of its job into the queue.
// Restart reloads state from the seed. Reset: seed and state return to 1, queue empty.
module rand_r_lcg_range_generator import rlcg_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = RLCG_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register write
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] range_low, [63:32] range_high
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] draw_value
);

    logic      q_push, q_pop, q_full, q_empty;
    t_draw_job q_in_job, q_out_job;

    // Front: command decode, three LCG steps per draw, span classification
    rlcg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_cmd       (i_s_axis_tuser),
        .i_low       (i_s_axis_tdata[31:0]),
        .i_high      (i_s_axis_tdata[63:32]),
        .o_push      (q_push),
        .o_job       (q_in_job),
        .i_full      (q_full)
    );

    // Queue lets the front keep queuing draws while a scaled draw is in the back end
    rlcg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (q_in_job),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_job  (q_out_job),
        .o_empty    (q_empty)
    );

    // Back: value*span, then floor(./divisor) via reciprocal, plus range_low
    rlcg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (q_out_job),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

    // Front never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("push into full queue");

    // Back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_empty))
        else $error("pop from empty queue");

    // A restart transfer never stalls the front: the front is ready again next
    a_restart_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_RESTART))
        |=> o_s_axis_tready)
        else $error("restart stalled the front end");

    // A draw transfer always leads to a queue push in F_STEP3 (after F_STEP2) when not full
    a_draw_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready &&
         ((i_s_axis_tuser == CMD_RAW) || (i_s_axis_tuser == CMD_RANGE)))
        |=> ##1 (q_push || q_full))
        else $error("draw did not reach the queue");

endmodule

@@ hdl/rlcg_front.sv @@
// Front end: accepts commands, steps the LCG state and queues finished draws.
module rlcg_front import rlcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_low,
    input  logic [31:0] i_high,
    output logic        o_push,
    output t_draw_job   o_job,
    input  logic        i_full
);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_STEP2 = 4'b0010,
        F_STEP3 = 4'b0100,
        F_PUSH  = 4'b1000
    } t_front_state;

    t_front_state r_fsm, n_fsm;
    logic [31:0]  r_seed;
    logic [31:0]  r_state, n_state;
    logic [30:0]  r_val, n_val;
    t_job_kind    r_kind, n_kind;
    logic [31:0]  r_low, n_low;
    logic [31:0]  r_span, n_span;

    logic [31:0]  lcg_next;
    logic [32:0]  span_wide;
    logic [30:0]  final_val;
    logic         accept;

    assign lcg_next  = r_state * RLCG_LCG_MUL + RLCG_LCG_INC;
    assign span_wide = {i_high[31], i_high} - {i_low[31], i_low};
    assign final_val = {r_val[20:0], lcg_next[25:16]};
    assign accept    = i_valid && o_ready;

    assign o_ready = (r_fsm == F_IDLE);
    assign o_push  = ((r_fsm == F_STEP3) || (r_fsm == F_PUSH)) && !i_full;

    always_comb begin
        o_job.kind  = r_kind;
        o_job.value = (r_fsm == F_STEP3) ? final_val : r_val;
        o_job.low   = r_low;
        o_job.span  = r_span;
    end

    always_comb begin
        n_fsm   = r_fsm;
        n_state = r_state;
        n_val   = r_val;
        n_kind  = r_kind;
        n_low   = r_low;
        n_span  = r_span;
        case (r_fsm)
            F_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_RAW, CMD_RANGE: begin
                            n_state = lcg_next;
                            n_val   = {20'b0, lcg_next[26:16]};
                            n_low   = i_low;
                            n_span  = span_wide[31:0];
                            if (i_cmd == CMD_RAW) begin
                                n_kind = JOB_RAW;
                            end else if (!span_wide[32] && (span_wide != 33'd0)) begin
                                n_kind = JOB_SCALE;
                            end else begin
                                n_kind = JOB_EMPTY;
                            end
                            n_fsm = F_STEP2;
                        end
                        CMD_RESTART: begin
                            n_state = r_seed;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            F_STEP2: begin
                n_state = lcg_next;
                n_val   = {r_val[20:0], lcg_next[25:16]};
                n_fsm   = F_STEP3;
            end
            F_STEP3: begin
                n_state = lcg_next;
                n_val   = final_val;
                n_fsm   = i_full ? F_PUSH : F_IDLE;
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_fsm = F_IDLE;
                end
            end
            default: begin
                n_fsm = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= F_IDLE;
            r_state <= RLCG_SEED_RESET;
            r_seed  <= RLCG_SEED_RESET;
        end else begin
            r_fsm   <= n_fsm;
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_kind <= n_kind;
        r_low  <= n_low;
        r_span <= n_span;
    end

endmodule

@@ hdl/rlcg_fifo.sv @@
// Short job queue between the front and back ends.
module rlcg_fifo import rlcg_pkg::*; #(
    parameter int unsigned DEPTH = RLCG_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_draw_job i_push_job,
    output logic      o_full,
    input  logic      i_pop,
    output t_draw_job o_pop_job,
    output logic      o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_draw_job     r_mem [DEPTH];
    logic [AW:0]   r_wr_ptr, r_rd_ptr;

    assign o_empty   = (r_wr_ptr == r_rd_ptr);
    assign o_full    = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                       (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_pop_job = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_push_job;
        end
    end

endmodule

@@ hdl/rlcg_back.sv @@
// Back end: range scaling by reciprocal multiply and the output register.
module rlcg_back import rlcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_draw_job   i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_ACC  = 3'b010,
        B_DONE = 3'b100
    } t_back_state;

    localparam logic [2:0] LAST_STEP = 3'd5;

    t_back_state   r_fsm, n_fsm;
    logic [2:0]    r_step;
    logic [62:0]   r_prod;
    logic [158:0]  r_acc;
    logic [31:0]   r_low;
    logic          r_ovalid;
    logic [31:0]   r_odata;

    logic          out_free;
    logic          load_out;
    logic [31:0]   out_next;
    logic [31:0]   op_a, op_b;
    logic [63:0]   pp;
    logic [158:0]  pp_sh;
    logic [2:0]    offset;

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = (r_fsm == B_IDLE) && !i_empty &&
                      ((i_job.kind == JOB_SCALE) || out_free);

    // Partial product order: (0,0) (1,0) (0,1) (1,1) (0,2) (1,2)
    always_comb begin
        op_a = r_step[0] ? {1'b0, r_prod[62:32]} : r_prod[31:0];
        case (r_step[2:1])
            2'd0:    op_b = RLCG_RECIP[31:0];
            2'd1:    op_b = RLCG_RECIP[63:32];
            default: op_b = RLCG_RECIP[95:64];
        endcase
    end

    assign pp     = {32'b0, op_a} * {32'b0, op_b};
    assign offset = {2'b0, r_step[0]} + {1'b0, r_step[2:1]};

    always_comb begin
        case (offset)
            3'd0:    pp_sh = {95'b0, pp};
            3'd1:    pp_sh = {95'b0, pp} << 32;
            3'd2:    pp_sh = {95'b0, pp} << 64;
            default: pp_sh = {95'b0, pp} << 96;
        endcase
    end

    always_comb begin
        n_fsm    = r_fsm;
        load_out = 1'b0;
        out_next = r_low + r_acc[126:95];
        case (r_fsm)
            B_IDLE: begin
                if (o_pop) begin
                    case (i_job.kind)
                        JOB_RAW: begin
                            load_out = 1'b1;
                            out_next = {1'b0, i_job.value};
                        end
                        JOB_SCALE: begin
                            n_fsm = B_ACC;
                        end
                        default: begin
                            load_out = 1'b1;
                            out_next = i_job.low;
                        end
                    endcase
                end
            end
            B_ACC: begin
                if (r_step == LAST_STEP) begin
                    n_fsm = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_fsm    = B_IDLE;
                end
            end
            default: begin
                n_fsm = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_odata <= out_next;
        end
        if (o_pop) begin
            r_low  <= i_job.low;
            r_prod <= 63'({33'b0, i_job.value} * {32'b0, i_job.span});
            r_step <= 3'd0;
        end else if (r_fsm == B_ACC) begin
            r_step <= r_step + 3'd1;
            r_acc  <= (r_step == 3'd0) ? pp_sh : r_acc + pp_sh;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule
